FILE: design/dmrq_pkg.sv
// Shared types, codes and default sizes for the deadline-monotonic ready queue.
package dmrq_pkg;

  localparam int DEF_QUEUE_DEPTH   = 16;
  localparam int DEF_ID_BITS       = 8;
  localparam int DEF_DEADLINE_BITS = 32;

  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK   = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic accept;
    logic scan_step;
    logic apply;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_stop;
    logic out_free;
  } dp_status_t;

endpackage

FILE: design/deadline_monotonic_ready_queue.sv
// Top level of the deadline-monotonic ready queue: stream ports, controller and datapath.
//
// Each input item inserts a job, removes a job by id or only peeks, and yields one
// result with a status, the most urgent job and the number of jobs held. Jobs are
// kept sorted by deadline with ties in arrival order. An item passes through the scan,
// apply and result states on its way from acceptance to the result register: the scan
// pointer visits the sorted entries one per cycle until it finds the place to insert,
// the id to remove or the end of the held jobs, then the apply state shifts the entries
// in parallel. A peek or a refused insert stops the scan at its first step. A new item
// is accepted as soon as the previous one has reached the result register, even while
// that result still waits to be taken.
module deadline_monotonic_ready_queue #(
  parameter int QUEUE_DEPTH   = dmrq_pkg::DEF_QUEUE_DEPTH,
  parameter int ID_BITS       = dmrq_pkg::DEF_ID_BITS,
  parameter int DEADLINE_BITS = dmrq_pkg::DEF_DEADLINE_BITS,
  localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1),
  localparam int IN_W         = ((ID_BITS + DEADLINE_BITS + 7) / 8) * 8,
  localparam int OUT_RAW_W    = 1 + ID_BITS + DEADLINE_BITS + CNT_W,
  localparam int OUT_W        = ((OUT_RAW_W + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // Fields from bit 0: job_id, rel_deadline, zero fill.
  input  logic [IN_W-1:0]               in_tdata,
  // Fields from bit 0: cmd.
  input  logic [dmrq_pkg::CMD_W-1:0]    in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // Fields from bit 0: head_valid, head_job_id, head_deadline, entry_count, zero fill.
  output logic [OUT_W-1:0]              out_tdata,
  // Fields from bit 0: status.
  output logic [dmrq_pkg::STATUS_W-1:0] out_tuser
);

  dmrq_pkg::ctrl_cmd_t  cmd;
  dmrq_pkg::dp_status_t sts;

  logic                     head_valid;
  logic [ID_BITS-1:0]       head_job_id;
  logic [DEADLINE_BITS-1:0] head_deadline;
  logic [CNT_W-1:0]         entry_count;

  dmrq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dmrq_datapath #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .ID_BITS       (ID_BITS),
    .DEADLINE_BITS (DEADLINE_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_cmd            (in_tuser),
    .in_job_id         (in_tdata[ID_BITS-1:0]),
    .in_rel_deadline   (in_tdata[ID_BITS +: DEADLINE_BITS]),
    .out_tready        (out_tready),
    .out_valid         (out_tvalid),
    .out_status        (out_tuser),
    .out_head_valid    (head_valid),
    .out_head_job_id   (head_job_id),
    .out_head_deadline (head_deadline),
    .out_entry_count   (entry_count)
  );

  assign out_tdata = OUT_W'({entry_count, head_deadline, head_job_id, head_valid});

endmodule

FILE: design/dmrq_ctrl.sv
// Controller state machine that sequences scan, update and result hand-off.
module dmrq_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  dmrq_pkg::dp_status_t  sts,
  output dmrq_pkg::ctrl_cmd_t   cmd
);

  dmrq_pkg::state_t state_r;
  dmrq_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dmrq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dmrq_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = dmrq_pkg::ST_SCAN;
        end
      end
      dmrq_pkg::ST_SCAN: begin
        if (sts.scan_stop) begin
          state_nxt = dmrq_pkg::ST_APPLY;
        end
      end
      dmrq_pkg::ST_APPLY: begin
        state_nxt = dmrq_pkg::ST_RESULT;
      end
      dmrq_pkg::ST_RESULT: begin
        if (sts.out_free) begin
          state_nxt = dmrq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dmrq_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready     = 1'b0;
    cmd.accept    = 1'b0;
    cmd.scan_step = 1'b0;
    cmd.apply     = 1'b0;
    cmd.load_out  = 1'b0;
    case (state_r)
      dmrq_pkg::ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      dmrq_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      dmrq_pkg::ST_APPLY: begin
        cmd.apply = 1'b1;
      end
      dmrq_pkg::ST_RESULT: begin
        cmd.load_out = sts.out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

FILE: design/dmrq_datapath.sv
// Datapath with the sorted entry registers, scan pointer and result register.
module dmrq_datapath #(
  parameter int QUEUE_DEPTH   = dmrq_pkg::DEF_QUEUE_DEPTH,
  parameter int ID_BITS       = dmrq_pkg::DEF_ID_BITS,
  parameter int DEADLINE_BITS = dmrq_pkg::DEF_DEADLINE_BITS,
  localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1),
  localparam int IDX_W        = $clog2(QUEUE_DEPTH)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dmrq_pkg::ctrl_cmd_t           cmd,
  output dmrq_pkg::dp_status_t          sts,
  input  logic [dmrq_pkg::CMD_W-1:0]    in_cmd,
  input  logic [ID_BITS-1:0]            in_job_id,
  input  logic [DEADLINE_BITS-1:0]      in_rel_deadline,
  input  logic                          out_tready,
  output logic                          out_valid,
  output logic [dmrq_pkg::STATUS_W-1:0] out_status,
  output logic                          out_head_valid,
  output logic [ID_BITS-1:0]            out_head_job_id,
  output logic [DEADLINE_BITS-1:0]      out_head_deadline,
  output logic [CNT_W-1:0]              out_entry_count
);

  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

  logic [ID_BITS-1:0]       entry_id_r [QUEUE_DEPTH];
  logic [DEADLINE_BITS-1:0] entry_dl_r [QUEUE_DEPTH];
  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         idx_r;
  logic [dmrq_pkg::CMD_W-1:0] op_r;
  logic [ID_BITS-1:0]       id_r;
  logic [DEADLINE_BITS-1:0] dl_r;

  logic                          out_valid_r;
  logic [dmrq_pkg::STATUS_W-1:0] out_status_r;
  logic                          out_head_valid_r;
  logic [ID_BITS-1:0]            out_id_r;
  logic [DEADLINE_BITS-1:0]      out_dl_r;
  logic [CNT_W-1:0]              out_count_r;
  logic [dmrq_pkg::STATUS_W-1:0] status_r;

  logic                     is_ins;
  logic                     is_rem;
  logic                     full;
  logic                     at_end;
  logic [ID_BITS-1:0]       rd_id;
  logic [DEADLINE_BITS-1:0] rd_dl;
  logic                     hit;

  assign is_ins = (op_r == dmrq_pkg::CMD_INSERT);
  assign is_rem = (op_r == dmrq_pkg::CMD_REMOVE);
  assign full   = (count_r == FULL_COUNT);
  assign at_end = (idx_r == count_r);
  assign rd_id  = entry_id_r[idx_r[IDX_W-1:0]];
  assign rd_dl  = entry_dl_r[idx_r[IDX_W-1:0]];
  assign hit    = is_ins ? (rd_dl > dl_r) : (rd_id == id_r);

  assign sts.scan_stop = !(is_ins || is_rem) || (is_ins && full) || at_end || hit;
  assign sts.out_free  = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.accept) begin
      idx_r <= '0;
    end else if (cmd.scan_step && !sts.scan_stop) begin
      idx_r <= idx_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r <= in_cmd;
      id_r <= in_job_id;
      dl_r <= in_rel_deadline;
    end
  end

  // Inserts open a gap at the scan position; removes close the gap there.
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      if (is_ins && !full) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
          if (CNT_W'(i) == idx_r) begin
            entry_id_r[i] <= id_r;
            entry_dl_r[i] <= dl_r;
          end else if ((i > 0) && (CNT_W'(i) > idx_r)) begin
            entry_id_r[i] <= entry_id_r[(i > 0) ? i - 1 : 0];
            entry_dl_r[i] <= entry_dl_r[(i > 0) ? i - 1 : 0];
          end
        end
      end else if (is_rem && !at_end) begin
        for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
          if (CNT_W'(i) >= idx_r) begin
            entry_id_r[i] <= entry_id_r[i + 1];
            entry_dl_r[i] <= entry_dl_r[i + 1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.apply) begin
      if (is_ins && !full) begin
        count_r <= count_r + CNT_W'(1);
      end else if (is_rem && !at_end) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      if (is_ins && full) begin
        status_r <= dmrq_pkg::STATUS_FULL;
      end else if (is_rem && at_end) begin
        status_r <= dmrq_pkg::STATUS_NOT_FOUND;
      end else begin
        status_r <= dmrq_pkg::STATUS_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r     <= status_r;
      out_head_valid_r <= (count_r != '0);
      out_id_r         <= (count_r != '0) ? entry_id_r[0] : '0;
      out_dl_r         <= (count_r != '0) ? entry_dl_r[0] : '0;
      out_count_r      <= count_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_head_valid    = out_head_valid_r;
  assign out_head_job_id   = out_id_r;
  assign out_head_deadline = out_dl_r;
  assign out_entry_count   = out_count_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_COUNT)
    else $error("entry count exceeds queue depth");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= count_r)
    else $error("scan pointer ran past the held entries");

  a_reject_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply && is_ins && full |=> count_r == $past(count_r))
    else $error("rejected insert changed the entry count");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_tready))
    else $error("result register overwritten while still held");
`endif

endmodule
